### rtl/infix_digit_expression_evaluator_macros.svh
// Assertion macros used by the checker of the expression evaluator.
`ifndef INFIX_DIGIT_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_DIGIT_EXPRESSION_EVALUATOR_MACROS_SVH

// Clocked property, switched off while reset is high.
`define IEXP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication in the same cycle.
`define IEXP_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   `IEXP_ASSERT(label, clk, rst, (pre) |-> (post), msg)

// Implication in the next cycle.
`define IEXP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   `IEXP_ASSERT(label, clk, rst, (pre) |=> (post), msg)

`endif

### rtl/iexp_pkg.sv
// Package: character codes, operator and status codes, divider interface types.
`timescale 1ns / 1ps
package iexp_pkg;

   localparam int CHAR_W   = 8;
   localparam int DATA_W   = 32;
   localparam int DIGIT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_MOD  = 8'h25;
   localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;

   // One restoring step per cycle over the dividend bits.
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2,
      OP_MOD  = 2'd3
   } mul_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_DIGIT   = 2'd1,
      ST_DIVZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic               start;
      logic               want_rem;
      logic [DIGIT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } div_rsp_type;

endpackage

### rtl/iexp_div.sv
// Iterative signed divider by a one-digit divisor, truncating toward zero.
`timescale 1ns / 1ps
module iexp_div import iexp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   input  logic [DATA_W-1:0] div_numer,
   output div_rsp_type       div_rsp
);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIN
   } dv_state_type;

   dv_state_type         state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [DIGIT_W-1:0]   divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic                 want_rem_ff, want_rem_in;

   logic [DIGIT_W:0]     shifted;
   logic                 fits;
   logic [DIGIT_W:0]     diff;
   logic [DATA_W-1:0]    mag_sel;

   // one restoring step
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign diff    = shifted - {1'b0, divisor_ff};

   assign mag_sel = want_rem_ff ? {{(DATA_W-DIGIT_W){1'b0}}, rem_ff} : quo_ff;

   assign div_rsp.done   = (state_ff == DV_FIN);
   assign div_rsp.result = neg_ff ? (DATA_W'(0) - mag_sel) : mag_sel;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      want_rem_in = want_rem_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               neg_in      = div_numer[DATA_W-1];
               quo_in      = div_numer[DATA_W-1] ? (DATA_W'(0) - div_numer) : div_numer;
               rem_in      = '0;
               count_in    = '0;
               divisor_in  = div_req.divisor;
               want_rem_in = div_req.want_rem;
               state_in    = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in   = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
            quo_in   = {quo_ff[DATA_W-2:0], fits};
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = DV_FIN;
            end
         end
         DV_FIN: begin
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      want_rem_ff <= want_rem_in;
   end

endmodule

### rtl/infix_digit_expression_evaluator.sv
// Top level: character-serial infix evaluator with two precedence levels.
//
//   channel | dir | payload                                   | note
//   req_    | in  | tdata[7:0] char_code                      | one ASCII char a beat
//   rsp_    | out | tdata[31:0] value, tuser[1:0] status      | one beat per expression
//
// Division: a digit after '/' or '%' is accepted, run through the shared one-bit-a-cycle
//   restoring divider and written back to the term; every other character is handled
//   as it is accepted.
// Reset: synchronous, active high; expression state cleared, no beat pending.
// Stalls: req_tready is low while dividing and while a result beat waits
//   unaccepted; it rises in the cycle the waiting beat is taken.
`timescale 1ns / 1ps
module infix_digit_expression_evaluator import iexp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CHAR_W-1:0]   req_tdata,   // [7:0] char_code
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [31:0] value
   output logic [STATUS_W-1:0] rsp_tuser    // [1:0] status
);

   typedef enum logic {
      S_IDLE,
      S_DIVIDE
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;        // finished terms
   logic               sub_ff, sub_in;        // next term subtracted
   logic [DATA_W-1:0]  term_ff, term_in;      // current term
   mul_op_type         op_ff, op_in;          // pending * / %
   logic               expect_ff, expect_in;  // a digit must come next

   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_value_ff, out_value_in;
   status_type         out_status_ff, out_status_in;

   logic                       accept;
   logic                       is_digit;
   logic [DIGIT_W-1:0]         digit;
   logic [DATA_W+DIGIT_W-1:0]  product;
   logic [DATA_W-1:0]          fold;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   assign req_tready = (state_ff == S_IDLE) && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign digit    = DIGIT_W'(req_tdata - CH_ZERO);
   assign product  = term_ff * digit;
   assign fold     = sub_ff ? (sum_ff - term_ff) : (sum_ff + term_ff);

   // divider launched straight from the accepting edge
   assign div_req.start    = accept && expect_ff && is_digit && (digit != '0)
                             && ((op_ff == OP_DIV) || (op_ff == OP_MOD));
   assign div_req.want_rem = (op_ff == OP_MOD);
   assign div_req.divisor  = digit;

   iexp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .div_numer (term_ff),
      .div_rsp   (div_rsp)
   );

   always_comb begin
      logic emit;
      emit          = 1'b0;
      state_in      = state_ff;
      sum_in        = sum_ff;
      sub_in        = sub_ff;
      term_in       = term_ff;
      op_in         = op_ff;
      expect_in     = expect_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (expect_ff) begin
                  if (!is_digit) begin
                     emit          = 1'b1;
                     out_value_in  = '0;
                     out_status_in = ST_DIGIT;
                  end else begin
                     unique case (op_ff)
                        OP_MUL: begin
                           term_in   = product[DATA_W-1:0];
                           op_in     = OP_NONE;
                           expect_in = 1'b0;
                        end
                        OP_DIV, OP_MOD: begin
                           if (digit == '0) begin
                              emit          = 1'b1;
                              out_value_in  = '0;
                              out_status_in = ST_DIVZERO;
                           end else begin
                              state_in = S_DIVIDE;
                           end
                        end
                        OP_NONE: begin
                           term_in   = {{(DATA_W-DIGIT_W){1'b0}}, digit};
                           expect_in = 1'b0;
                        end
                        default: begin
                           term_in = term_ff;
                        end
                     endcase
                  end
               end else begin
                  priority if (req_tdata == CH_MUL) begin
                     op_in     = OP_MUL;
                     expect_in = 1'b1;
                  end else if (req_tdata == CH_DIV) begin
                     op_in     = OP_DIV;
                     expect_in = 1'b1;
                  end else if (req_tdata == CH_MOD) begin
                     op_in     = OP_MOD;
                     expect_in = 1'b1;
                  end else if ((req_tdata == CH_ADD) || (req_tdata == CH_SUB)) begin
                     sum_in    = fold;
                     term_in   = '0;
                     sub_in    = (req_tdata == CH_SUB);
                     op_in     = OP_NONE;
                     expect_in = 1'b1;
                  end else begin
                     // terminator
                     emit          = 1'b1;
                     out_value_in  = fold;
                     out_status_in = ST_OK;
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               term_in   = div_rsp.result;
               op_in     = OP_NONE;
               expect_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         sum_in       = '0;
         sub_in       = 1'b0;
         term_in      = '0;
         op_in        = OP_NONE;
         expect_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         sub_ff       <= 1'b0;
         term_ff      <= '0;
         op_ff        <= OP_NONE;
         expect_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sub_ff       <= sub_in;
         term_ff      <= term_in;
         op_ff        <= op_in;
         expect_ff    <= expect_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

### rtl/iexp_checker.sv
// Port-level checker for the expression evaluator, bound to the top level.
`timescale 1ns / 1ps
`include "infix_digit_expression_evaluator_macros.svh"
module iexp_checker import iexp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [DATA_W-1:0]   rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   logic                       rsp_stall;
   logic                       rsp_err;
   logic                       req_fire;
   logic [DATA_W+STATUS_W-1:0] rsp_beat;
   logic [DATA_W+STATUS_W-1:0] beat_ff;
   logic                       rsp_kept;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_err   = rsp_tvalid && (rsp_tuser != ST_OK);
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_beat  = {rsp_tdata, rsp_tuser};
   assign rsp_kept  = rsp_tvalid && (rsp_beat == beat_ff);

   // previous cycle's result payload
   always_ff @(posedge clock) begin
      beat_ff <= rsp_beat;
   end

   // stalled result beat holds its payload
   `IEXP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_kept, "stalled beat changed")

   // error beats carry a zero value
   `IEXP_ASSERT_IMP(a_err_zero, clock, reset, rsp_err, rsp_tdata == '0, "error beat not zero")

   // no new character while a result waits untaken
   `IEXP_ASSERT_IMP(a_block_in, clock, reset, rsp_stall, !req_tready, "input open in stall")

   // a result only ever follows an accepted character
   `IEXP_ASSERT_IMP(a_cause, clock, reset, $rose(rsp_tvalid), $past(req_fire), "result uncaused")

endmodule

bind infix_digit_expression_evaluator iexp_checker u_iexp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/sv/tb_top.sv
// Self-checking bench for the infix digit expression evaluator: directed table, then random.
`timescale 1ns / 1ps
module tb_top;
   import iexp_pkg::*;

   // Counts and windows
   localparam int RANDOM_CHARS   = 1250;
   localparam int SETTLE_CYCLES  = 40;    // one divide plus margin
   localparam int HOLD_CYCLES    = 400;   // long output stall, forces input back-pressure
   localparam int HOLD_AFTER     = 30;    // results seen before the long stall starts
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [DATA_W-1:0] value;
      status_type        status;
   } eval_result_type;

   // One directed beat; the expected result is typed in only where it is obvious.
   typedef struct {
      logic [CHAR_W-1:0] ch;
      bit                fixed;
      logic [DATA_W-1:0] value;
      status_type        status;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CHAR_W-1:0]   req_tdata = '0;     // [7:0] char_code
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;          // [31:0] value
   logic [STATUS_W-1:0] rsp_tuser;          // [1:0] status

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   infix_digit_expression_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Directed table: bad starts, zero divisors, extreme terminators, a precedence mix
   stim_row_type directed_rows [0:25] = '{
      '{CH_ADD,            1'b1, 32'd0, ST_DIGIT},   // operator where an operand is due
      '{8'h00,             1'b1, 32'd0, ST_DIGIT},   // lowest code at the start
      '{8'hFF,             1'b1, 32'd0, ST_DIGIT},   // highest code at the start
      '{CH_ZERO + 8'd7,    1'b0, 32'd0, ST_OK},
      '{CH_DIV,            1'b0, 32'd0, ST_OK},
      '{CH_ZERO,           1'b1, 32'd0, ST_DIVZERO}, // divide by zero
      '{CH_ZERO + 8'd5,    1'b0, 32'd0, ST_OK},
      '{CH_MOD,            1'b0, 32'd0, ST_OK},
      '{CH_ZERO,           1'b1, 32'd0, ST_DIVZERO}, // modulo by zero
      '{CH_NINE,           1'b0, 32'd0, ST_OK},
      '{8'h00,             1'b1, 32'd9, ST_OK},      // NUL ends the expression
      '{CH_ZERO,           1'b0, 32'd0, ST_OK},
      '{8'hFF,             1'b1, 32'd0, ST_OK},
      '{CH_ZERO + 8'd3,    1'b0, 32'd0, ST_OK},
      '{CH_SUB,            1'b0, 32'd0, ST_OK},
      '{CH_MUL,            1'b1, 32'd0, ST_DIGIT},   // operator straight after operator
      '{CH_ZERO + 8'd8,    1'b0, 32'd0, ST_OK},
      '{CH_SUB,            1'b0, 32'd0, ST_OK},
      '{CH_NINE,           1'b0, 32'd0, ST_OK},
      '{CH_MUL,            1'b0, 32'd0, ST_OK},
      '{CH_ZERO + 8'd7,    1'b0, 32'd0, ST_OK},
      '{CH_DIV,            1'b0, 32'd0, ST_OK},
      '{CH_ZERO + 8'd2,    1'b0, 32'd0, ST_OK},
      '{CH_MOD,            1'b0, 32'd0, ST_OK},
      '{CH_ZERO + 8'd5,    1'b0, 32'd0, ST_OK},
      '{8'h3D,             1'b0, 32'd0, ST_OK}       // '=' as terminator
   };

   // Expression state mirrored from the block
   logic [DATA_W-1:0] sum_acc;
   logic [DATA_W-1:0] term_acc;
   bit                sub_pending;
   mul_op_type        mul_pending;
   bit                want_digit;

   eval_result_type pending_results [$];
   int              chars_sent = 0;
   int              results_seen = 0;
   int              mismatches = 0;
   int              value_results = 0;
   int              digit_errors = 0;
   int              divzero_errors = 0;

   function automatic void clear_eval();
      sum_acc     = '0;
      term_acc    = '0;
      sub_pending = 1'b0;
      mul_pending = OP_NONE;
      want_digit  = 1'b1;
   endfunction

   function automatic bit is_operator(input logic [CHAR_W-1:0] c);
      return c == CH_MUL || c == CH_DIV || c == CH_MOD || c == CH_ADD || c == CH_SUB;
   endfunction

   // Advances the mirrored state by one character; returns 1 when a result is due.
   function automatic bit eval_char(input logic [CHAR_W-1:0] c, output eval_result_type r);
      logic [DATA_W-1:0] digit;
      int                dividend;
      int                divisor;
      r.value  = '0;
      r.status = ST_OK;
      if (want_digit) begin
         if (c < CH_ZERO || c > CH_NINE) begin
            r.status = ST_DIGIT;
            clear_eval();
            return 1'b1;
         end
         digit    = DATA_W'(c - CH_ZERO);
         dividend = term_acc;
         divisor  = digit;
         case (mul_pending)
            OP_MUL: begin
               term_acc = term_acc * digit;
            end
            OP_DIV, OP_MOD: begin
               if (digit == '0) begin
                  r.status = ST_DIVZERO;
                  clear_eval();
                  return 1'b1;
               end
               // int division truncates toward zero; remainder keeps dividend sign
               term_acc = (mul_pending == OP_DIV) ? dividend / divisor : dividend % divisor;
            end
            default: begin
               term_acc = digit;
            end
         endcase
         mul_pending = OP_NONE;
         want_digit  = 1'b0;
         return 1'b0;
      end
      if (c == CH_MUL || c == CH_DIV || c == CH_MOD) begin
         mul_pending = (c == CH_MUL) ? OP_MUL : (c == CH_DIV) ? OP_DIV : OP_MOD;
         want_digit  = 1'b1;
         return 1'b0;
      end
      if (c == CH_ADD || c == CH_SUB) begin
         sum_acc     = sub_pending ? sum_acc - term_acc : sum_acc + term_acc;
         term_acc    = '0;
         sub_pending = (c == CH_SUB);
         mul_pending = OP_NONE;
         want_digit  = 1'b1;
         return 1'b0;
      end
      r.value = sub_pending ? sum_acc - term_acc : sum_acc + term_acc;
      clear_eval();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input eval_result_type want,
                                  input eval_result_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t %s: expected value %0d status %0d, got value %0d status %0d",
                  $time, what, $signed(want.value), want.status,
                  $signed(got.value), got.status);
   endtask

   // Offers one character from a falling edge; returns at the falling edge after the beat.
   // Idles about 9 in 100 beats, none in the quiet window.
   task automatic put_char(input logic [CHAR_W-1:0] c, input bit fixed,
                           input eval_result_type fixed_r);
      eval_result_type r;
      bit              due;
      while (!(chars_sent >= 500 && chars_sent < 750) && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      due = eval_char(c, r);
      if (fixed)
         r = fixed_r;
      if (due || fixed)
         pending_results.push_back(r);
      chars_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed expressions with random digits and operators; some have one
   // character overwritten by a random byte, some beats are pure noise.
   task automatic random_expression();
      logic [CHAR_W-1:0] seq [$];
      logic [CHAR_W-1:0] term_char;
      eval_result_type   none;
      int                kind;
      int                operands;
      int                pick;
      none.value  = '0;
      none.status = ST_OK;
      kind = $urandom_range(99);
      if (kind < 10) begin
         put_char(CHAR_W'($urandom_range(255)), 1'b0, none);
         return;
      end
      // long chains now and then, so products wrap and negative terms get divided
      operands = ($urandom_range(7) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
      for (int i = 0; i < operands; i++) begin
         seq.push_back(($urandom_range(99) < 30) ? CH_NINE
                                                 : CH_ZERO + CHAR_W'($urandom_range(9)));
         if (i < operands - 1) begin
            pick = $urandom_range(99);
            seq.push_back(pick < 40 ? CH_MUL : pick < 55 ? CH_DIV : pick < 65 ? CH_MOD :
                          pick < 85 ? CH_ADD : CH_SUB);
         end
      end
      do term_char = CHAR_W'($urandom_range(255)); while (is_operator(term_char));
      seq.push_back(term_char);
      if (kind < 20)
         seq[$urandom_range(seq.size() - 1)] = CHAR_W'($urandom_range(255));
      foreach (seq[i])
         put_char(seq[i], 1'b0, none);
   endtask

   // Result side: ready decided at the falling edge. One long hold-off after a few
   // results; a quiet window with no idling; otherwise about 9 idle cycles in 100.
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (results_seen >= 120 && results_seen < 220) || $urandom_range(99) >= 9;
      end
   end

   // Checker: every result beat against the oldest expectation
   always @(posedge clock) begin
      eval_result_type got;
      eval_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata;
         got.status = status_type'(rsp_tuser);
         results_seen++;
         case (got.status)
            ST_OK:      value_results++;
            ST_DIGIT:   digit_errors++;
            ST_DIVZERO: divzero_errors++;
            default:    ;
         endcase
         if (pending_results.size() == 0) begin
            want.value  = '0;
            want.status = ST_OK;
            report_mismatch("result beat with nothing expected", want, got);
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.status !== want.status)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // Guard: stops a hung run and reports a mismatch
   initial begin
      #5_000_000;
      $display("infix_digit_expression_evaluator: mismatch");
      $finish;
   end

   initial begin
      eval_result_type fixed_r;
      clear_eval();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         fixed_r.value  = directed_rows[i].value;
         fixed_r.status = directed_rows[i].status;
         put_char(directed_rows[i].ch, directed_rows[i].fixed, fixed_r);
      end
      while (chars_sent < $size(directed_rows) + RANDOM_CHARS)
         random_expression();
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      // a trailing divide may still be running with no result to come
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d characters; checked %0d result beats: %0d values, %0d digit errors,",
               chars_sent, results_seen, value_results, digit_errors);
      $display("%0d zero divisors, with random idling, a quiet stretch and a long output stall.",
               divzero_errors);
      if (mismatches == 0)
         $display("infix_digit_expression_evaluator: match");
      else
         $display("infix_digit_expression_evaluator: mismatch");
      $finish;
   end

endmodule
